@@ design/rcle_pkg.sv @@
package rcle_pkg;

   // Field widths fixed by the interface.
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;
   localparam int KIND_W  = 2;

   // Transaction kinds.
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // Operation carried through the search.
   typedef enum logic {
      OP_LOAD,
      OP_QUERY
   } op_type;

endpackage

@@ design/rcle_ram.sv @@
// Simple dual-port store: one write and one registered read per cycle.
module rcle_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [rcle_pkg::VALUE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [rcle_pkg::VALUE_W-1:0]  rd_data
);

   logic [rcle_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [rcle_pkg::VALUE_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rcle_cmp.sv @@
// Shared signed compare unit: is the stored entry less than or equal to the key?
module rcle_cmp (
   input  logic signed [rcle_pkg::VALUE_W-1:0] entry,
   input  logic signed [rcle_pkg::VALUE_W-1:0] key,
   output logic                                le
);

   assign le = (entry <= key);

endmodule

@@ design/rank_count_less_equal.sv @@
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_kind, req_value, req_last_in_batch
// rsp       out        rsp_valid, rsp_ready, rsp_count, rsp_last, rsp_dropped
//
// The store is kept sorted. A query runs an upper-bound binary search with one
// memory read per step: each step reads the midpoint entry, then compares it
// with the key. A load runs the same search, then moves the larger entries up
// one place, each by a read then a write, then writes the new value. Clears,
// dropped loads and unused kinds finish in the idle state. The memory has a
// single read port. Reset clears the count and the dropped flag; the store needs
// no clearing. A stalled result waits in the output register while the next
// transaction is taken; a finished query waits in S_RESP until it is free.
module rank_count_less_equal #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rcle_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [rcle_pkg::VALUE_W-1:0] req_value,
   input  logic                                req_last_in_batch,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rcle_pkg::COUNT_W-1:0]        rsp_count,
   output logic                                rsp_last,
   output logic                                rsp_dropped
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

   state_type                          state_ff, state_in;
   rcle_pkg::op_type                   op_ff, op_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic                               dropped_ff, dropped_in;
   logic [CW-1:0]                      lo_ff, lo_in;
   logic [CW-1:0]                      hi_ff, hi_in;
   logic [CW-1:0]                      mid_ff, mid_in;
   logic [CW-1:0]                      pos_ff, pos_in;
   logic signed [rcle_pkg::VALUE_W-1:0] key_ff, key_in;
   logic                               last_ff, last_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rcle_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_dropped_ff, rsp_dropped_in;

   logic [CW:0]                        mid_sum;
   logic [CW-1:0]                      mid;
   logic [CW+rcle_pkg::COUNT_W-1:0]    lo_ext;
   logic [CW-1:0]                      pos_dec;
   logic                               req_take;

   logic                               ram_we;
   logic [AW-1:0]                      ram_waddr;
   logic [rcle_pkg::VALUE_W-1:0]       ram_wdata;
   logic                               ram_re;
   logic [AW-1:0]                      ram_raddr;
   logic [rcle_pkg::VALUE_W-1:0]       ram_rdata;
   logic                               entry_le;

   rcle_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rcle_cmp u_cmp (
      .entry (ram_rdata),
      .key   (key_ff),
      .le    (entry_le)
   );

   // Midpoint of the search window and helpers.
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CW:1];
   assign lo_ext   = {{rcle_pkg::COUNT_W{1'b0}}, lo_ff};
   assign pos_dec  = pos_ff - CW'(1);
   assign req_take = req_valid && req_ready;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_dropped = rsp_dropped_ff;

   // Sequencer next-state and datapath control.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cnt_in         = cnt_ff;
      dropped_in     = dropped_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      pos_in         = pos_ff;
      key_in         = key_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_dropped_in = rsp_dropped_ff;
      ram_we         = 1'b0;
      ram_waddr      = pos_ff[AW-1:0];
      ram_wdata      = ram_rdata;
      ram_re         = 1'b0;
      ram_raddr      = mid[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               key_in  = req_value;
               last_in = req_last_in_batch;
               lo_in   = '0;
               hi_in   = cnt_ff;
               unique case (req_kind)
                  rcle_pkg::KIND_LOAD: begin
                     if (cnt_ff == DEPTH_C) begin
                        dropped_in = 1'b1;
                     end else begin
                        op_in    = rcle_pkg::OP_LOAD;
                        state_in = S_SEARCH;
                     end
                  end
                  rcle_pkg::KIND_QUERY: begin
                     op_in    = rcle_pkg::OP_QUERY;
                     state_in = S_SEARCH;
                  end
                  rcle_pkg::KIND_CLEAR: begin
                     cnt_in     = '0;
                     dropped_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               // Fetch the midpoint entry; it is compared next cycle.
               ram_re   = 1'b1;
               mid_in   = mid;
               state_in = S_CMP;
            end else if (op_ff == rcle_pkg::OP_QUERY) begin
               state_in = S_RESP;
            end else begin
               pos_in   = cnt_ff;
               state_in = S_SHIFT_RD;
            end
         end
         S_CMP: begin
            if (entry_le) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_SHIFT_RD: begin
            if (pos_ff > lo_ff) begin
               // Read the entry below the hole.
               ram_re    = 1'b1;
               ram_raddr = pos_dec[AW-1:0];
               state_in  = S_SHIFT_WR;
            end else begin
               // Insert the new value at its sorted place.
               ram_we    = 1'b1;
               ram_waddr = lo_ff[AW-1:0];
               ram_wdata = key_ff;
               cnt_in    = cnt_ff + CW'(1);
               state_in  = S_IDLE;
            end
         end
         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = ram_rdata;
            pos_in    = pos_dec;
            state_in  = S_SHIFT_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = lo_ext[rcle_pkg::COUNT_W-1:0];
               rsp_last_in    = last_ff;
               rsp_dropped_in = dropped_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      pos_ff         <= pos_in;
      key_ff         <= key_in;
      last_ff        <= last_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

`ifndef SYNTHESIS
   // The store never holds more than its depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("stored count exceeds depth");

   // The search window stays ordered and within the stored entries.
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_CMP) |-> (lo_ff <= hi_ff && hi_ff <= cnt_ff))
      else $error("search window out of order");

   // The shift never moves past the insertion point.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_WR) |-> (pos_ff > lo_ff && pos_ff <= cnt_ff))
      else $error("shift index out of range");

   // A finished query is presented on the next cycle.
   a_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) |=> (rsp_valid && req_ready))
      else $error("query result not presented");
`endif

endmodule
